[hdl/spr_pkg.sv]
package spr_pkg;

  localparam int CAR_W  = 11;
  localparam int LEN_W  = 11;
  localparam int DATA_W = 16;

  localparam logic [LEN_W-1:0] SEQ_LEN_RST = LEN_W'(1024);

  typedef enum logic {
    KIND_DIRECT = 1'b0,
    KIND_POP    = 1'b1
  } move_kind_t;

  localparam int KIND_BIT = 0;
  localparam int FAIL_BIT = 1;

endpackage

[hdl/spr_ram.sv]
module spr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/stack_permutation_router.sv]
// Channel   Direction  Handshake          Payload
// cfg       in         cfg_we             cfg_wdata = seq_length
// s         in         s_tvalid/s_tready  s_tdata = car, s_tuser = first
// m         out        m_tvalid/m_tready  m_tdata = pushes, m_tuser = move_kind, fail
//
// An item settled on the memory read data alone (pop, waiting car not on top, or
// already failed) is accepted, then decided. Any other item is accepted, decided, then
// given a push step per car pushed and a final one; the single stack write port sets the
// push rate. Reset is synchronous and needs no clearing pass: map entries at or above the
// next source car are never consulted. A new item is accepted while a result waits on m;
// the decision step and the final push step hold until the output register is free.
module stack_permutation_router #(
  parameter int MAX_CARS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [spr_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [spr_pkg::DATA_W-1:0]     s_tdata,   // [10:0] car
  input  logic [0:0]                     s_tuser,   // [0] first
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spr_pkg::DATA_W-1:0]     m_tdata,   // [10:0] pushes
  output logic [1:0]                     m_tuser    // [0] move_kind, [1] fail
);

  localparam int CAR_W = spr_pkg::CAR_W;
  localparam int AW    = $clog2(MAX_CARS);
  localparam int DPW   = $clog2(MAX_CARS + 1);
  localparam int NXW   = $clog2(MAX_CARS + 2);
  localparam int CW    = (NXW > CAR_W) ? NXW : CAR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_PUSH
  } state_t;

  state_t                    state;
  logic [spr_pkg::LEN_W-1:0] seq_length;
  logic [DPW-1:0]            depth;
  logic [NXW-1:0]            next_src;
  logic                      failed;
  logic [CAR_W-1:0]          car_q;
  logic [CAR_W-1:0]          pushes;

  logic             in_acc;
  logic             first_in;
  logic [CAR_W-1:0] car_in;
  logic [DPW-1:0]   depth_eff;
  logic [DPW-1:0]   depth_m1;
  logic [CW-1:0]    car_in_m1;
  logic [NXW-1:0]   next_m1;
  logic [CW-1:0]    seq_ext;
  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    car_c;
  logic [CW-1:0]    next_c;
  logic [CW-1:0]    depth_c;
  logic             waiting;
  logic             top_hit;
  logic             out_free;
  logic             out_load;
  logic             push_go;
  logic             direct_ok;

  logic             stack_we;
  logic [CAR_W-1:0] stack_rd;
  logic             map_we;
  logic             map_rd;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign first_in = s_tuser[0];
  assign car_in   = s_tdata[CAR_W-1:0];

  assign depth_eff = first_in ? '0 : depth;
  assign depth_m1  = depth_eff - DPW'(1);
  assign car_in_m1 = CW'(car_in) - CW'(1);
  assign next_m1   = next_src - NXW'(1);

  always_comb begin
    seq_ext = CW'(seq_length);
    if (seq_ext == '0) begin
      n_eff = CW'(1);
    end else if (seq_ext > CW'(MAX_CARS)) begin
      n_eff = CW'(MAX_CARS);
    end else begin
      n_eff = seq_ext;
    end
  end

  assign car_c     = CW'(car_q);
  assign next_c    = CW'(next_src);
  assign depth_c   = CW'(depth);
  assign waiting   = (car_c != '0) && (car_c <= n_eff) && (car_c < next_c) && map_rd;
  assign top_hit   = (depth != '0) && (stack_rd == car_q);
  assign out_free  = !m_tvalid || m_tready;
  assign push_go   = (next_c <= n_eff) && (next_c != car_c) && (depth_c < CW'(MAX_CARS));
  assign direct_ok = (next_c <= n_eff) && (next_c == car_c);
  assign out_load  = out_free && (((state == S_DEC) && (failed || waiting)) ||
                                  ((state == S_PUSH) && !push_go));

  assign stack_we = (state == S_PUSH) && push_go;
  assign map_we   = (state == S_PUSH) && (push_go || (out_free && direct_ok));

  spr_ram #(
    .DEPTH (MAX_CARS),
    .WIDTH (CAR_W)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (depth[AW-1:0]),
    .wdata (CAR_W'(next_src)),
    .re    (in_acc),
    .raddr (depth_m1[AW-1:0]),
    .rdata (stack_rd)
  );

  spr_ram #(
    .DEPTH (MAX_CARS),
    .WIDTH (1)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (next_m1[AW-1:0]),
    .wdata (push_go),
    .re    (in_acc),
    .raddr (car_in_m1[AW-1:0]),
    .rdata (map_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= spr_pkg::SEQ_LEN_RST;
    end else if (cfg_we) begin
      seq_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      depth    <= '0;
      next_src <= NXW'(1);
      failed   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            car_q  <= car_in;
            pushes <= '0;
            if (first_in) begin
              depth    <= '0;
              next_src <= NXW'(1);
              failed   <= 1'b0;
            end
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (out_free) begin
            priority if (failed) begin
              m_tdata  <= '0;
              m_tuser  <= {1'b1, spr_pkg::KIND_DIRECT};
              state    <= S_IDLE;
            end else if (waiting) begin
              m_tdata  <= '0;
              if (top_hit) begin
                depth   <= depth - DPW'(1);
                m_tuser <= {1'b0, spr_pkg::KIND_POP};
              end else begin
                failed  <= 1'b1;
                m_tuser <= {1'b1, spr_pkg::KIND_DIRECT};
              end
              state <= S_IDLE;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_PUSH: begin
          if (push_go) begin
            depth    <= depth + DPW'(1);
            next_src <= next_src + NXW'(1);
            pushes   <= pushes + CAR_W'(1);
          end else if (out_free) begin
            m_tdata  <= spr_pkg::DATA_W'(pushes);
            if (direct_ok) begin
              next_src <= next_src + NXW'(1);
              m_tuser  <= {1'b0, spr_pkg::KIND_DIRECT};
            end else begin
              failed  <= 1'b1;
              m_tuser <= {1'b1, spr_pkg::KIND_DIRECT};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_depth_below_next: assert property (@(posedge clk) disable iff (rst)
    CW'(depth) < CW'(next_src))
    else $error("side stack deeper than cars taken from source");

  a_pop_not_failed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[spr_pkg::KIND_BIT] |-> !m_tuser[spr_pkg::FAIL_BIT])
    else $error("pop reported together with failure");

  a_push_grows_stack: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) && push_go |=> depth == $past(depth) + DPW'(1))
    else $error("push did not advance stack depth");
`endif

endmodule
